// ----- rtl/core/ddo_pkg.sv -----
package ddo_pkg;

  localparam int TickBits    = 16;
  localparam int CordicSteps = 16;
  localparam int StepBits    = 5;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_ANGLE = 2'd2;

  localparam logic signed [33:0] CordicStart = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CORDIC,
    ST_TRIG,
    ST_POS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic cordic_init;
    logic cordic_step;
    logic trig;
    logic pos;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
  } sts_t;

  function automatic logic signed [33:0] atan_val(input logic [4:0] i);
    case (i)
      5'd0:  atan_val = 34'sh20000000;
      5'd1:  atan_val = 34'sh12E4051E;
      5'd2:  atan_val = 34'sh09FB385B;
      5'd3:  atan_val = 34'sh051111D4;
      5'd4:  atan_val = 34'sh028B0D43;
      5'd5:  atan_val = 34'sh0145D7E1;
      5'd6:  atan_val = 34'sh00A2F61E;
      5'd7:  atan_val = 34'sh00517C55;
      5'd8:  atan_val = 34'sh0028BE53;
      5'd9:  atan_val = 34'sh00145F2F;
      5'd10: atan_val = 34'sh000A2F98;
      5'd11: atan_val = 34'sh000517CC;
      5'd12: atan_val = 34'sh00028BE6;
      5'd13: atan_val = 34'sh000145F3;
      5'd14: atan_val = 34'sh0000A2F9;
      5'd15: atan_val = 34'sh0000517C;
      5'd16: atan_val = 34'sh000028BE;
      5'd17: atan_val = 34'sh0000145F;
      5'd18: atan_val = 34'sh00000A2F;
      5'd19: atan_val = 34'sh00000517;
      5'd20: atan_val = 34'sh0000028B;
      5'd21: atan_val = 34'sh00000145;
      5'd22: atan_val = 34'sh000000A2;
      5'd23: atan_val = 34'sh00000051;
      default: atan_val = 34'sh0;
    endcase
  endfunction

endpackage

// ----- rtl/core/differential_drive_odometry.sv -----
// Channel | Direction | Ports
// in      | request   | in_valid, in_stall, in_left_delta, in_right_delta
// out     | result    | out_valid, out_stall, out_x, out_y, out_heading
// cfg     | APB write | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata
// A request passes from acceptance to a valid result through one wheel multiply,
// one sum, sixteen CORDIC iterations on one shared shift-add unit plus a finishing
// step, scaling by sine and cosine, and one pose update.
// A new request is taken in the cycle after the previous result has been taken, so
// requests never overlap; a stalled result delays the next request.
// Reset is synchronous and active low; it clears the pose and restores the scales.
// A stalled result holds its value until out_stall drops.
module differential_drive_odometry (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ddo_pkg::TickBits-1:0] in_left_delta,
  input  logic signed [ddo_pkg::TickBits-1:0] in_right_delta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  out_x,
  output logic signed [31:0]                  out_y,
  output logic [15:0]                         out_heading,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [3:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import ddo_pkg::*;

  logic [23:0] left_r, right_r, angle_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;
  logic [1:0] reg_idx;

  // Registers sit at word addresses; the low two address bits are ignored.
  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 24'd65536;
      right_r <= 24'd65536;
      angle_r <= 24'd5696256;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEFT:  left_r  <= cfg_pwdata[23:0];
        REG_RIGHT: right_r <= cfg_pwdata[23:0];
        REG_ANGLE: angle_r <= cfg_pwdata[23:0];
        default:   left_r  <= left_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEFT:  cfg_prdata = {8'd0, left_r};
      REG_RIGHT: cfg_prdata = {8'd0, right_r};
      REG_ANGLE: cfg_prdata = {8'd0, angle_r};
      default:   cfg_prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .rst_n       (rst_n),
    .left_delta  (in_left_delta),
    .right_delta (in_right_delta),
    .left_scale  (left_r),
    .right_scale (right_r),
    .angle_scale (angle_r),
    .pos_x       (out_x),
    .pos_y       (out_y),
    .heading     (out_heading)
  );

  // The block never accepts a request while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request accepted with result pending");

  // A pose update only happens right before the result appears.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos |=> out_valid) else $error("pose update without result");

  // A stalled result keeps its x position and heading.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_heading))
    else $error("result changed under stall");

endmodule

// ----- rtl/core/ddo_ctrl.sv -----
module ddo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ddo_pkg::sts_t sts,
  output ddo_pkg::cmd_t cmd
);
  import ddo_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_CORDIC;
      ST_CORDIC: if (sts.cordic_done) state_nxt = ST_TRIG;
      ST_TRIG:   state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL:    cmd.mul = 1'b1;
      ST_SUM: begin
        cmd.sum = 1'b1;
        cmd.cordic_init = 1'b1;
      end
      ST_CORDIC: cmd.cordic_step = !sts.cordic_done;
      ST_TRIG:   cmd.trig = 1'b1;
      ST_POS:    cmd.pos = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/ddo_dp.sv -----
module ddo_dp (
  input  logic                              clk,
  input  ddo_pkg::cmd_t                     cmd,
  output ddo_pkg::sts_t                     sts,
  input  logic                              rst_n,
  input  logic signed [ddo_pkg::TickBits-1:0] left_delta,
  input  logic signed [ddo_pkg::TickBits-1:0] right_delta,
  input  logic [23:0]                       left_scale,
  input  logic [23:0]                       right_scale,
  input  logic [23:0]                       angle_scale,
  output logic signed [31:0]                pos_x,
  output logic signed [31:0]                pos_y,
  output logic [15:0]                       heading
);
  import ddo_pkg::*;

  localparam int WheelBits = TickBits + 25;

  logic signed [TickBits-1:0]  ld_r, rd_r;
  logic signed [WheelBits-1:0] dl_r, dr_r;
  logic signed [WheelBits-8:0] d_r;
  logic [15:0]                 dh_r;
  logic signed [33:0]          cx_r, cy_r, cz_r;
  logic                        flip_r;
  logic [StepBits-1:0]         step_r;
  logic signed [31:0]          px_r, py_r;
  logic [15:0]                 hd_r;
  logic signed [WheelBits-8+16:0] mx_r, my_r;

  logic signed [WheelBits:0]   wsum, wdiff;
  logic [63:0]                 aprod;
  logic [31:0]                 za, zf;
  logic signed [33:0]          ysh, xsh, at;
  logic signed [33:0]          cxr, cyr;
  logic signed [33:0]          cneg, sneg;
  logic signed [33:0]          rx, ry;
  logic signed [33:0]          nx, ny;
  logic signed [WheelBits-8+16:0] stx, sty;
  logic signed [33:0]          sumx, sumy;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) sat = 32'sh7FFFFFFF;
    else if (v < -34'sh080000000) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  assign wsum  = WheelBits'(dl_r) + WheelBits'(dr_r);
  assign wdiff = {dr_r[WheelBits-1], dr_r} - {dl_r[WheelBits-1], dl_r};
  assign aprod = 64'(wdiff) * {40'd0, angle_scale} + 64'h80000000;

  assign za = {hd_r, 16'd0};
  assign zf = za + 32'h80000000;

  assign ysh = cy_r >>> step_r;
  assign xsh = cx_r >>> step_r;
  assign at  = atan_val(step_r);

  always_comb begin
    if (!cz_r[33]) begin
      nx = cx_r - ysh;
      ny = cy_r + xsh;
    end else begin
      nx = cx_r + ysh;
      ny = cy_r - xsh;
    end
  end

  assign cneg = -cx_r;
  assign sneg = -cy_r;
  assign cxr  = flip_r ? cneg : cx_r;
  assign cyr  = flip_r ? sneg : cy_r;
  assign rx   = (cxr + 34'sd32768) >>> 16;
  assign ry   = (cyr + 34'sd32768) >>> 16;

  assign stx  = (mx_r + 8192) >>> 14;
  assign sty  = (my_r + 8192) >>> 14;
  assign sumx = 34'(px_r) + 34'(stx);
  assign sumy = 34'(py_r) + 34'(sty);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ld_r <= left_delta;
      rd_r <= right_delta;
    end
    if (cmd.mul) begin
      dl_r <= WheelBits'(ld_r) * $signed({1'b0, left_scale});
      dr_r <= WheelBits'(rd_r) * $signed({1'b0, right_scale});
    end
    if (cmd.sum) begin
      d_r  <= (WheelBits-7)'((wsum + 256) >>> 9);
      dh_r <= aprod[47:32];
    end
    if (cmd.cordic_init) begin
      flip_r <= za[31] ^ za[30];
      cx_r <= CordicStart;
      cy_r <= '0;
      cz_r <= (za[31] ^ za[30]) ? 34'(signed'(zf)) : 34'(signed'(za));
    end else if (cmd.cordic_step) begin
      cx_r <= nx;
      cy_r <= ny;
      cz_r <= cz_r[33] ? cz_r + at : cz_r - at;
    end
  end

  // The CORDIC step counter advances here; the rounded sine and cosine feed the distance products directly.
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) step_r <= '0;
    else if (cmd.cordic_step) step_r <= step_r + 1'b1;
    if (cmd.trig) begin
      mx_r <= d_r * $signed(rx[15:0]);
      my_r <= d_r * $signed(ry[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
      hd_r <= '0;
    end else if (cmd.pos) begin
      px_r <= sat(sumx);
      py_r <= sat(sumy);
      hd_r <= hd_r + dh_r;
    end
  end

  assign sts.cordic_done = (step_r == StepBits'(CordicSteps));
  assign pos_x = px_r;
  assign pos_y = py_r;
  assign heading = hd_r;

endmodule
